>>> hdl/u16u8_pkg.sv
// ----------------------------------------------------------------------------
// u16u8_pkg
// Shared types and constants of the UTF-16BE / UTF-8 string converter.
// ----------------------------------------------------------------------------
package u16u8_pkg;

  localparam int WIN_BYTES  = 8;
  localparam int WIN_IDX_W  = $clog2(WIN_BYTES);
  localparam int FILL_W     = $clog2(WIN_BYTES + 1);

  localparam int LOOK_U16    = 8;
  localparam int LOOK_U8     = 6;
  localparam int UNIT_BYTES  = 2;
  localparam int PAIR_BYTES  = 4;
  localparam int ESC16_SHORT = 6;
  localparam int ESC16_LONG  = 8;
  localparam int ESC8_SHORT  = 4;
  localparam int ESC8_LONG   = 6;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] BOM16_0 = 8'd254;
  localparam logic [7:0] BOM16_1 = 8'd255;
  localparam logic [7:0] BOM8_0  = 8'd239;
  localparam logic [7:0] BOM8_1  = 8'd187;
  localparam logic [7:0] BOM8_2  = 8'd191;
  localparam logic [7:0] ESC     = 8'd27;

  localparam int CP_W = 21;
  localparam logic [15:0]     SURR_FIRST = 16'hD800;
  localparam logic [15:0]     SURR_LAST  = 16'hDFFF;
  localparam logic [CP_W:0]   LOW_SURR   = 22'h00DC00;
  localparam logic [CP_W:0]   CP_PLANE1  = 22'h010000;
  localparam logic [CP_W-1:0] CP_MAX     = 21'h10FFFF;
  localparam logic [CP_W-1:0] CP_REPL    = 21'h00FFFD;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       raw_doc_byte;
    logic       out_last;
  } out_item_t;

  typedef enum logic [1:0] {MODE_DETECT, MODE_U16, MODE_U8, MODE_RAW} mode_t;
  typedef enum logic {ST_ACCEPT, ST_DRAIN} fstate_t;
  typedef enum logic [1:0] {OP_CP, OP_BYTE, OP_RAW, OP_END} op_kind_t;

  typedef struct packed {
    op_kind_t        kind;
    logic [CP_W-1:0] value;
    logic            last;
  } op_t;

  typedef struct packed {
    logic valid;
    op_t  op;
  } push_t;

endpackage

>>> hdl/u16u8_front.sv
// ----------------------------------------------------------------------------
// u16u8_front
// Byte intake: mark detection, lookahead window and decode into ops.
// ----------------------------------------------------------------------------
module u16u8_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  u16u8_pkg::in_item_t in_data,
  input  logic                q_ready,
  output u16u8_pkg::push_t    push
);

  u16u8_pkg::fstate_t state_r, state_nxt;
  u16u8_pkg::mode_t   mode_r, mode_nxt;
  logic [7:0] win_r [u16u8_pkg::WIN_BYTES];
  logic [7:0] win_nxt [u16u8_pkg::WIN_BYTES];
  logic [u16u8_pkg::FILL_W-1:0] fill_r, fill_nxt;
  logic fin_r, fin_nxt;
  logic pend_valid_r, pend_valid_nxt;
  u16u8_pkg::op_t pend_r, pend_nxt;

  logic [7:0] win_app [u16u8_pkg::WIN_BYTES];
  logic [u16u8_pkg::FILL_W-1:0] fill_app;
  logic [7:0] sw [u16u8_pkg::WIN_BYTES];
  logic [u16u8_pkg::FILL_W-1:0] sn;
  logic [7:0] win_shift [u16u8_pkg::WIN_BYTES];
  logic [u16u8_pkg::FILL_W-1:0] look_fill;

  logic st_op_valid;
  u16u8_pkg::op_t st_op;
  logic [u16u8_pkg::FILL_W-1:0] st_k;
  logic drain_cond;

  logic [15:0] unit_a, unit_b, a_off;
  logic [u16u8_pkg::CP_W:0] pair_sum;
  logic [u16u8_pkg::CP_W-1:0] pair_cp;

  logic det_u16, det_u8, det_flush;

  always_comb begin
    for (int i = 0; i < u16u8_pkg::WIN_BYTES; i++) begin
      win_app[i] = (fill_r == u16u8_pkg::FILL_W'(i)) ? in_data.in_byte : win_r[i];
    end
    fill_app = fill_r + u16u8_pkg::FILL_W'(1);
  end

  always_comb begin
    if (state_r == u16u8_pkg::ST_ACCEPT) begin
      sw = win_app;
      sn = fill_app;
    end else begin
      sw = win_r;
      sn = fill_r;
    end
  end

  assign look_fill = (mode_r == u16u8_pkg::MODE_U16) ? u16u8_pkg::FILL_W'(u16u8_pkg::LOOK_U16)
                                                     : u16u8_pkg::FILL_W'(u16u8_pkg::LOOK_U8);

  // surrogate join: high half minus D800 lands in bits [10:0]
  assign unit_a   = {sw[0], sw[1]};
  assign unit_b   = {sw[2], sw[3]};
  assign a_off    = unit_a - u16u8_pkg::SURR_FIRST;
  assign pair_sum = {1'b0, a_off[10:0], 10'b0} + {6'b0, unit_b}
                    + u16u8_pkg::CP_PLANE1 - u16u8_pkg::LOW_SURR;
  assign pair_cp  = (pair_sum > {1'b0, u16u8_pkg::CP_MAX}) ? u16u8_pkg::CP_REPL
                                                           : pair_sum[u16u8_pkg::CP_W-1:0];

  always_comb begin
    st_op_valid = 1'b0;
    st_op       = '0;
    st_k        = u16u8_pkg::FILL_W'(1);
    drain_cond  = 1'b0;
    unique case (mode_r)
      u16u8_pkg::MODE_U16: begin
        drain_cond = sn >= u16u8_pkg::FILL_W'(u16u8_pkg::UNIT_BYTES);
        if (sn >= u16u8_pkg::FILL_W'(u16u8_pkg::ESC16_SHORT) && sw[0] == 8'd0 &&
            sw[1] == u16u8_pkg::ESC && sw[4] == 8'd0 && sw[5] == u16u8_pkg::ESC) begin
          st_k = u16u8_pkg::FILL_W'(u16u8_pkg::ESC16_SHORT);
        end else if (sn >= u16u8_pkg::FILL_W'(u16u8_pkg::ESC16_LONG) && sw[0] == 8'd0 &&
                     sw[1] == u16u8_pkg::ESC && sw[6] == 8'd0 && sw[7] == u16u8_pkg::ESC) begin
          st_k = u16u8_pkg::FILL_W'(u16u8_pkg::ESC16_LONG);
        end else if (unit_a >= u16u8_pkg::SURR_FIRST && unit_a <= u16u8_pkg::SURR_LAST &&
                     sn >= u16u8_pkg::FILL_W'(u16u8_pkg::PAIR_BYTES)) begin
          st_k        = u16u8_pkg::FILL_W'(u16u8_pkg::PAIR_BYTES);
          st_op_valid = 1'b1;
          st_op.kind  = u16u8_pkg::OP_CP;
          st_op.value = pair_cp;
        end else begin
          st_k        = u16u8_pkg::FILL_W'(u16u8_pkg::UNIT_BYTES);
          st_op_valid = 1'b1;
          st_op.kind  = u16u8_pkg::OP_CP;
          st_op.value = {5'b0, unit_a};
        end
      end
      u16u8_pkg::MODE_U8: begin
        drain_cond = sn != '0;
        if (sn >= u16u8_pkg::FILL_W'(u16u8_pkg::ESC8_SHORT) &&
            sw[0] == u16u8_pkg::ESC && sw[3] == u16u8_pkg::ESC) begin
          st_k = u16u8_pkg::FILL_W'(u16u8_pkg::ESC8_SHORT);
        end else if (sn >= u16u8_pkg::FILL_W'(u16u8_pkg::ESC8_LONG) &&
                     sw[0] == u16u8_pkg::ESC && sw[5] == u16u8_pkg::ESC) begin
          st_k = u16u8_pkg::FILL_W'(u16u8_pkg::ESC8_LONG);
        end else begin
          st_op_valid = 1'b1;
          st_op.kind  = u16u8_pkg::OP_BYTE;
          st_op.value = {13'b0, sw[0]};
        end
      end
      u16u8_pkg::MODE_RAW: begin
        drain_cond  = sn != '0;
        st_op_valid = 1'b1;
        st_op.kind  = u16u8_pkg::OP_RAW;
        st_op.value = {13'b0, sw[0]};
      end
      u16u8_pkg::MODE_DETECT: begin
        drain_cond = 1'b0;
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < u16u8_pkg::WIN_BYTES; i++) begin
      if (i + int'(st_k) < u16u8_pkg::WIN_BYTES) begin
        win_shift[i] = sw[u16u8_pkg::WIN_IDX_W'(i + int'(st_k))];
      end else begin
        win_shift[i] = '0;
      end
    end
  end

  always_comb begin
    det_u16   = 1'b0;
    det_u8    = 1'b0;
    det_flush = 1'b0;
    priority if (win_app[0] == u16u8_pkg::BOM16_0) begin
      if (fill_app >= u16u8_pkg::FILL_W'(2)) begin
        det_u16   = win_app[1] == u16u8_pkg::BOM16_1;
        det_flush = win_app[1] != u16u8_pkg::BOM16_1;
      end else begin
        det_flush = in_data.in_last;
      end
    end else if (win_app[0] == u16u8_pkg::BOM8_0) begin
      if (fill_app >= u16u8_pkg::FILL_W'(2) && win_app[1] != u16u8_pkg::BOM8_1) begin
        det_flush = 1'b1;
      end else if (fill_app >= u16u8_pkg::FILL_W'(3)) begin
        det_u8    = win_app[2] == u16u8_pkg::BOM8_2;
        det_flush = win_app[2] != u16u8_pkg::BOM8_2;
      end else begin
        det_flush = in_data.in_last;
      end
    end else begin
      det_flush = 1'b1;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    win_nxt        = win_r;
    fill_nxt       = fill_r;
    fin_nxt        = fin_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    push           = '0;
    in_ready       = 1'b0;
    unique case (state_r)
      u16u8_pkg::ST_ACCEPT: begin
        in_ready = q_ready;
        if (in_valid && q_ready) begin
          unique case (mode_r)
            u16u8_pkg::MODE_RAW: begin
              push.valid    = 1'b1;
              push.op.kind  = u16u8_pkg::OP_RAW;
              push.op.value = {13'b0, in_data.in_byte};
              push.op.last  = in_data.in_last;
              if (in_data.in_last) begin
                mode_nxt = u16u8_pkg::MODE_DETECT;
                fill_nxt = '0;
              end
            end
            u16u8_pkg::MODE_DETECT: begin
              win_nxt  = win_app;
              fill_nxt = fill_app;
              if (det_u16) begin
                mode_nxt = u16u8_pkg::MODE_U16;
                fill_nxt = '0;
              end else if (det_u8) begin
                mode_nxt = u16u8_pkg::MODE_U8;
                fill_nxt = '0;
              end else if (det_flush) begin
                mode_nxt = u16u8_pkg::MODE_RAW;
              end
              if (det_flush || in_data.in_last) begin
                state_nxt = u16u8_pkg::ST_DRAIN;
                fin_nxt   = in_data.in_last;
              end
            end
            u16u8_pkg::MODE_U16, u16u8_pkg::MODE_U8: begin
              win_nxt  = win_app;
              fill_nxt = fill_app;
              if (in_data.in_last) begin
                state_nxt = u16u8_pkg::ST_DRAIN;
                fin_nxt   = 1'b1;
              end else if (fill_app == look_fill) begin
                push.valid = st_op_valid;
                push.op    = st_op;
                win_nxt    = win_shift;
                fill_nxt   = fill_app - st_k;
              end
            end
          endcase
        end
      end
      u16u8_pkg::ST_DRAIN: begin
        if (q_ready) begin
          if (drain_cond) begin
            win_nxt  = win_shift;
            fill_nxt = fill_r - st_k;
            if (st_op_valid) begin
              push.valid     = pend_valid_r;
              push.op        = pend_r;
              pend_nxt       = st_op;
              pend_valid_nxt = 1'b1;
            end
          end else begin
            state_nxt      = u16u8_pkg::ST_ACCEPT;
            pend_valid_nxt = 1'b0;
            if (fin_r) begin
              push.valid = 1'b1;
              if (pend_valid_r) begin
                push.op = pend_r;
              end else begin
                push.op.kind  = u16u8_pkg::OP_END;
                push.op.value = '0;
              end
              push.op.last = 1'b1;
              mode_nxt     = u16u8_pkg::MODE_DETECT;
              fill_nxt     = '0;
              fin_nxt      = 1'b0;
            end else begin
              push.valid = pend_valid_r;
              push.op    = pend_r;
            end
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= u16u8_pkg::ST_ACCEPT;
      mode_r       <= u16u8_pkg::MODE_DETECT;
      fill_r       <= '0;
      fin_r        <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      mode_r       <= mode_nxt;
      fill_r       <= fill_nxt;
      fin_r        <= fin_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r  <= win_nxt;
    pend_r <= pend_nxt;
  end

endmodule

>>> hdl/u16u8_fifo.sv
// ----------------------------------------------------------------------------
// u16u8_fifo
// Short op queue between intake and encoder.
// ----------------------------------------------------------------------------
module u16u8_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  u16u8_pkg::push_t push,
  output logic             q_ready,
  output logic             q_valid,
  output u16u8_pkg::op_t   q_data,
  input  logic             pop
);

  u16u8_pkg::op_t mem_r [u16u8_pkg::QDEPTH];
  logic [u16u8_pkg::QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [u16u8_pkg::QCNT_W-1:0] cnt_r;
  logic do_wr, do_rd;

  assign q_ready = cnt_r != u16u8_pkg::QCNT_W'(u16u8_pkg::QDEPTH);
  assign q_valid = cnt_r != '0;
  assign q_data  = mem_r[rd_ptr_r];
  assign do_wr   = push.valid && q_ready;
  assign do_rd   = pop && q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= wr_ptr_r + u16u8_pkg::QPTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr_r <= rd_ptr_r + u16u8_pkg::QPTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + u16u8_pkg::QCNT_W'(1);
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - u16u8_pkg::QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= push.op;
    end
  end

endmodule

>>> hdl/u16u8_back.sv
// ----------------------------------------------------------------------------
// u16u8_back
// UTF-8 encoder: expands one op into its bytes into the output register.
// ----------------------------------------------------------------------------
module u16u8_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  u16u8_pkg::op_t       q_data,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output u16u8_pkg::out_item_t out_data
);

  localparam logic [u16u8_pkg::CP_W-1:0] LIM_1B = 21'h000080;
  localparam logic [u16u8_pkg::CP_W-1:0] LIM_2B = 21'h000800;
  localparam logic [u16u8_pkg::CP_W-1:0] LIM_3B = 21'h010000;
  localparam logic [1:0] CONT_TAG = 2'b10;
  localparam logic [2:0] LEAD2    = 3'b110;
  localparam logic [3:0] LEAD3    = 4'b1110;
  localparam logic [4:0] LEAD4    = 5'b11110;

  logic out_valid_r;
  u16u8_pkg::out_item_t out_data_r;
  logic [1:0] idx_r;
  logic [1:0] len_m1, rem;
  logic [u16u8_pkg::CP_W-1:0] v;
  logic [7:0] enc_byte;
  logic final_byte, load;

  assign v = q_data.value;

  always_comb begin
    len_m1 = 2'd0;
    if (q_data.kind == u16u8_pkg::OP_CP) begin
      priority if (v < LIM_1B) begin
        len_m1 = 2'd0;
      end else if (v < LIM_2B) begin
        len_m1 = 2'd1;
      end else if (v < LIM_3B) begin
        len_m1 = 2'd2;
      end else begin
        len_m1 = 2'd3;
      end
    end
  end

  assign rem = len_m1 - idx_r;

  always_comb begin
    enc_byte = '0;
    unique case (q_data.kind)
      u16u8_pkg::OP_BYTE, u16u8_pkg::OP_RAW: enc_byte = v[7:0];
      u16u8_pkg::OP_END: enc_byte = '0;
      u16u8_pkg::OP_CP: begin
        if (idx_r == 2'd0) begin
          unique case (len_m1)
            2'd0: enc_byte = {1'b0, v[6:0]};
            2'd1: enc_byte = {LEAD2, v[10:6]};
            2'd2: enc_byte = {LEAD3, v[15:12]};
            2'd3: enc_byte = {LEAD4, v[20:18]};
          endcase
        end else begin
          case (rem)
            2'd0:    enc_byte = {CONT_TAG, v[5:0]};
            2'd1:    enc_byte = {CONT_TAG, v[11:6]};
            default: enc_byte = {CONT_TAG, v[17:12]};
          endcase
        end
      end
    endcase
  end

  assign final_byte = idx_r == len_m1;
  assign load       = !out_valid_r || out_ready;
  assign pop        = load && q_valid && final_byte;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else if (load) begin
      out_valid_r <= q_valid;
      if (q_valid) begin
        idx_r <= final_byte ? 2'd0 : idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && q_valid) begin
      out_data_r.out_byte     <= enc_byte;
      out_data_r.has_byte     <= q_data.kind != u16u8_pkg::OP_END;
      out_data_r.raw_doc_byte <= q_data.kind == u16u8_pkg::OP_RAW;
      out_data_r.out_last     <= q_data.last && final_byte;
    end
  end

endmodule

>>> hdl/utf16be_string_to_utf8.sv
// ----------------------------------------------------------------------------
// utf16be_string_to_utf8
// Text string to UTF-8 converter with byte-order-mark detection.
// ----------------------------------------------------------------------------
//  channel | signals                      | transaction
//  in      | in_valid/in_ready/in_data    | one string byte, in_last on final
//  out     | out_valid/out_ready/out_data | one UTF-8 or raw byte, or bare end marker
//
//  One byte accepted per cycle while the op queue has room and no drain runs;
//  results leave the encoder's output register at one byte per cycle while
//  out_ready is high. A byte flagged last holds intake while the decode
//  steps left in the lookahead window drain; a broken or missing mark holds
//  it while the held header bytes drain.
//  Reset is synchronous, with no clearing pass.
// ----------------------------------------------------------------------------
module utf16be_string_to_utf8 (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  u16u8_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output u16u8_pkg::out_item_t out_data
);

  u16u8_pkg::push_t push;
  logic q_ready, q_valid, pop;
  u16u8_pkg::op_t q_data;

  u16u8_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_ready  (q_ready),
    .push     (push)
  );

  u16u8_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .q_ready (q_ready),
    .q_valid (q_valid),
    .q_data  (q_data),
    .pop     (pop)
  );

  u16u8_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |-> q_ready)
    else $error("op pushed into full queue");

  a_end_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.has_byte |->
      out_data.out_last && out_data.out_byte == 8'd0 && !out_data.raw_doc_byte)
    else $error("malformed bare end marker");

  a_raw_has_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.raw_doc_byte |-> out_data.has_byte)
    else $error("raw flag without data byte");

endmodule

>>> tb/tb_utf16be_string_to_utf8.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_utf16be_string_to_utf8
// Self-checking bench for the text string to UTF-8 converter. Strings are
// built byte by byte: short directed cases for mark detection, then random
// UTF-16BE, UTF-8, raw and header-case strings. A local model of the
// converter predicts the result bytes of every accepted input transaction,
// and the monitor checks each result transaction against them in order.
// Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_utf16be_string_to_utf8;

  localparam int CYCLE_LIMIT      = 200000;
  localparam int MAX_IDLE         = 12;
  localparam int MAX_STEP_RESULTS = 16;
  localparam int RANDOM_BYTES     = 285;
  localparam int TAIL_CYCLES      = 40;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  u16u8_pkg::in_item_t  in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  u16u8_pkg::out_item_t out_data;

  utf16be_string_to_utf8 uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // stimulus and expectations
  u16u8_pkg::in_item_t  pending_bytes[$];
  logic [7:0]           str_buf[$];
  u16u8_pkg::out_item_t utf8_expected[$];

  int err_cnt = 0;
  int checked_cnt = 0;
  int cycle_cnt = 0;
  int n_u16 = 0, n_u8 = 0, n_raw = 0, n_hdr = 0, n_bytes = 0;

  // converter model state
  u16u8_pkg::mode_t conv_mode = u16u8_pkg::MODE_DETECT;
  logic [7:0]       win [0:u16u8_pkg::WIN_BYTES-1];
  int               win_fill = 0;
  logic [1:0]       hdr_cnt = '0;
  int               step_n;

  task automatic clear_state();
    conv_mode = u16u8_pkg::MODE_DETECT;
    for (int i = 0; i < u16u8_pkg::WIN_BYTES; i++) win[i] = '0;
    win_fill = 0;
    hdr_cnt = '0;
  endtask

  task automatic put_byte(input logic [31:0] v, input logic raw);
    u16u8_pkg::out_item_t r;
    if (step_n < MAX_STEP_RESULTS) begin
      r.out_byte = v[7:0];
      r.has_byte = 1'b1;
      r.raw_doc_byte = raw;
      r.out_last = 1'b0;
      utf8_expected.push_back(r);
      step_n++;
    end
  endtask

  task automatic drop(input int k);
    if (k >= win_fill) begin
      win_fill = 0;
    end else begin
      for (int i = 0; i < win_fill - k; i++) win[i] = win[i + k];
      win_fill = win_fill - k;
    end
  endtask

  task automatic put_rune(input logic [31:0] cp);
    logic [31:0] c;
    c = cp;
    if (c > 32'(u16u8_pkg::CP_MAX)) c = 32'(u16u8_pkg::CP_REPL);
    if (c < 32'h80) begin
      put_byte(c, 1'b0);
    end else if (c < 32'h800) begin
      put_byte(32'hC0 | (c >> 6), 1'b0);
      put_byte(32'h80 | (c & 32'h3F), 1'b0);
    end else if (c < 32'h10000) begin
      put_byte(32'hE0 | (c >> 12), 1'b0);
      put_byte(32'h80 | ((c >> 6) & 32'h3F), 1'b0);
      put_byte(32'h80 | (c & 32'h3F), 1'b0);
    end else begin
      put_byte(32'hF0 | (c >> 18), 1'b0);
      put_byte(32'h80 | ((c >> 12) & 32'h3F), 1'b0);
      put_byte(32'h80 | ((c >> 6) & 32'h3F), 1'b0);
      put_byte(32'h80 | (c & 32'h3F), 1'b0);
    end
  endtask

  task automatic decode_u16(input logic fin);
    int n;
    logic [31:0] a, lo, c;
    while (fin ? (win_fill >= u16u8_pkg::UNIT_BYTES) : (win_fill >= u16u8_pkg::LOOK_U16)) begin
      n = win_fill;
      if (n >= u16u8_pkg::ESC16_SHORT && win[0] == 8'd0 && win[1] == u16u8_pkg::ESC &&
          win[4] == 8'd0 && win[5] == u16u8_pkg::ESC) begin
        drop(u16u8_pkg::ESC16_SHORT);
      end else if (n >= u16u8_pkg::ESC16_LONG && win[0] == 8'd0 && win[1] == u16u8_pkg::ESC &&
                   win[6] == 8'd0 && win[7] == u16u8_pkg::ESC) begin
        drop(u16u8_pkg::ESC16_LONG);
      end else begin
        a = {16'h0, win[0], win[1]};
        if (a >= 32'(u16u8_pkg::SURR_FIRST) && a <= 32'(u16u8_pkg::SURR_LAST) &&
            n >= u16u8_pkg::PAIR_BYTES) begin
          lo = {16'h0, win[2], win[3]};
          c = ((a - 32'(u16u8_pkg::SURR_FIRST)) << 10) + lo + 32'(u16u8_pkg::CP_PLANE1)
              - 32'(u16u8_pkg::LOW_SURR);
          drop(u16u8_pkg::PAIR_BYTES);
          put_rune(c);
        end else begin
          drop(u16u8_pkg::UNIT_BYTES);
          put_rune(a);
        end
      end
    end
    if (fin) win_fill = 0;
  endtask

  task automatic decode_u8(input logic fin);
    int n;
    while (fin ? (win_fill >= 1) : (win_fill >= u16u8_pkg::LOOK_U8)) begin
      n = win_fill;
      if (n >= u16u8_pkg::ESC8_SHORT && win[0] == u16u8_pkg::ESC &&
          win[3] == u16u8_pkg::ESC) begin
        drop(u16u8_pkg::ESC8_SHORT);
      end else if (n >= u16u8_pkg::ESC8_LONG && win[0] == u16u8_pkg::ESC &&
                   win[5] == u16u8_pkg::ESC) begin
        drop(u16u8_pkg::ESC8_LONG);
      end else begin
        put_byte({24'h0, win[0]}, 1'b0);
        drop(1);
      end
    end
  endtask

  task automatic flush_held();
    for (int i = 0; i < win_fill && i < u16u8_pkg::WIN_BYTES; i++) begin
      put_byte({24'h0, win[i]}, 1'b1);
    end
    win_fill = 0;
    conv_mode = u16u8_pkg::MODE_RAW;
  endtask

  task automatic predict_utf8(input logic [7:0] b, input logic fin);
    u16u8_pkg::out_item_t r;
    int idx;
    step_n = 0;
    if (conv_mode == u16u8_pkg::MODE_RAW) begin
      put_byte({24'h0, b}, 1'b1);
    end else begin
      if (win_fill < u16u8_pkg::WIN_BYTES) begin
        win[win_fill] = b;
        win_fill++;
      end
      if (conv_mode == u16u8_pkg::MODE_DETECT) begin
        hdr_cnt = hdr_cnt + 2'd1;
        if (win[0] == u16u8_pkg::BOM16_0) begin
          if (win_fill >= 2) begin
            if (win[1] == u16u8_pkg::BOM16_1) begin
              conv_mode = u16u8_pkg::MODE_U16;
              win_fill = 0;
            end else begin
              flush_held();
            end
          end else if (fin) begin
            flush_held();
          end
        end else if (win[0] == u16u8_pkg::BOM8_0) begin
          if (win_fill >= 2 && win[1] != u16u8_pkg::BOM8_1) begin
            flush_held();
          end else if (win_fill >= 3) begin
            if (win[2] == u16u8_pkg::BOM8_2) begin
              conv_mode = u16u8_pkg::MODE_U8;
              win_fill = 0;
            end else begin
              flush_held();
            end
          end else if (fin) begin
            flush_held();
          end
        end else begin
          flush_held();
        end
      end else if (conv_mode == u16u8_pkg::MODE_U16) begin
        decode_u16(fin);
      end else begin
        decode_u8(fin);
      end
    end
    if (fin) begin
      if (step_n == 0) begin
        r = '0;
        utf8_expected.push_back(r);
      end
      idx = utf8_expected.size() - 1;
      r = utf8_expected[idx];
      r.out_last = 1'b1;
      utf8_expected[idx] = r;
      clear_state();
    end
  endtask

  // string building
  task automatic add(input logic [7:0] b);
    str_buf.push_back(b);
  endtask

  task automatic add16(input logic [15:0] u);
    str_buf.push_back(u[15:8]);
    str_buf.push_back(u[7:0]);
  endtask

  task automatic commit_string();
    u16u8_pkg::in_item_t it;
    for (int i = 0; i < str_buf.size(); i++) begin
      it.in_byte = str_buf[i];
      it.in_last = (i == str_buf.size() - 1);
      pending_bytes.push_back(it);
    end
    n_bytes += str_buf.size();
    str_buf.delete();
  endtask

  function automatic logic [7:0] rnd8();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [15:0] rnd16(input int lo, input int hi);
    return 16'($urandom_range(lo, hi));
  endfunction

  function automatic logic [7:0] byte_except(input logic [7:0] no);
    logic [7:0] v;
    v = rnd8();
    while (v == no) v = rnd8();
    return v;
  endfunction

  task automatic gen_u16();
    int units;
    logic [15:0] u;
    add(u16u8_pkg::BOM16_0);
    add(u16u8_pkg::BOM16_1);
    units = ($urandom_range(0, 9) == 0) ? int'($urandom_range(7, 14))
                                        : int'($urandom_range(0, 6));
    for (int i = 0; i < units; i++) begin
      case ($urandom_range(0, 9))
        0: add16(rnd16(16'h0000, 16'h007F));
        1: add16(rnd16(16'h0080, 16'h07FF));
        2: add16(rnd16(16'h0800, 16'hFFFF));
        3: begin
          add16(rnd16(16'hD800, 16'hDBFF));
          add16(rnd16(16'hDC00, 16'hDFFF));
        end
        4: begin
          add16(rnd16(16'hD800, 16'hDFFF));
          add16(rnd16(0, 16'hFFFF));
        end
        5: begin
          add16({8'd0, u16u8_pkg::ESC});
          add16(rnd16(0, 16'hFFFF));
          add16({8'd0, u16u8_pkg::ESC});
        end
        6: begin
          add16({8'd0, u16u8_pkg::ESC});
          add16(rnd16(0, 16'hFFFF));
          add16(rnd16(0, 16'hFFFF));
          add16({8'd0, u16u8_pkg::ESC});
        end
        7: begin
          case ($urandom_range(0, 4))
            0: add16(16'h0000);
            1: add16(16'hFFFF);
            2: begin add16(16'hDBFF); add16(16'hDFFF); end
            3: begin add16(16'hDFFF); add16(16'hFFFF); end
            default: begin add16(16'hD800); add16(16'hDC00); end
          endcase
        end
        8: begin
          u = rnd16(0, 16'hFFFF);
          add16(u);
        end
        default: add16(rnd16(16'h0000, 16'h00FF));
      endcase
    end
    if ($urandom_range(0, 5) == 0) add16(rnd16(16'hD800, 16'hDFFF));
    if ($urandom_range(0, 4) == 0) add(rnd8());
    n_u16++;
    commit_string();
  endtask

  task automatic gen_u8();
    int len;
    add(u16u8_pkg::BOM8_0);
    add(u16u8_pkg::BOM8_1);
    add(u16u8_pkg::BOM8_2);
    len = int'($urandom_range(0, 10));
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 5))
        0: begin
          add(u16u8_pkg::ESC); add(rnd8()); add(rnd8()); add(u16u8_pkg::ESC);
        end
        1: begin
          add(u16u8_pkg::ESC);
          for (int k = 0; k < 4; k++) add(rnd8());
          add(u16u8_pkg::ESC);
        end
        2: add(u16u8_pkg::ESC);
        3: add($urandom_range(0, 1) ? 8'hFF : 8'h00);
        default: add(rnd8());
      endcase
    end
    n_u8++;
    commit_string();
  endtask

  task automatic gen_raw();
    logic [7:0] b;
    int len;
    b = rnd8();
    while (b == u16u8_pkg::BOM16_0 || b == u16u8_pkg::BOM8_0) b = rnd8();
    add(b);
    len = int'($urandom_range(0, 8));
    for (int i = 0; i < len; i++) add(rnd8());
    n_raw++;
    commit_string();
  endtask

  task automatic gen_header_case();
    int tail;
    case ($urandom_range(0, 8))
      0: add(u16u8_pkg::BOM16_0);
      1: add(u16u8_pkg::BOM8_0);
      2: begin add(u16u8_pkg::BOM8_0); add(u16u8_pkg::BOM8_1); end
      3: begin add(u16u8_pkg::BOM16_0); add(u16u8_pkg::BOM16_1); end
      4: begin add(u16u8_pkg::BOM16_0); add(byte_except(u16u8_pkg::BOM16_1)); end
      5: begin add(u16u8_pkg::BOM8_0); add(byte_except(u16u8_pkg::BOM8_1)); end
      6: begin
        add(u16u8_pkg::BOM8_0); add(u16u8_pkg::BOM8_1); add(byte_except(u16u8_pkg::BOM8_2));
      end
      7: begin add(u16u8_pkg::BOM16_0); add(u16u8_pkg::BOM16_1); add(rnd8()); end
      default: begin add(u16u8_pkg::BOM8_0); add(u16u8_pkg::BOM8_1); add(u16u8_pkg::BOM8_2); end
    endcase
    tail = ($urandom_range(0, 1) == 0) ? 0 : int'($urandom_range(1, 5));
    for (int i = 0; i < tail; i++) add(rnd8());
    n_hdr++;
    commit_string();
  endtask

  task automatic build_stimulus();
    int pick;
    // directed: short header, empty strings, broken marks, lone surrogate, odd tail
    add(u16u8_pkg::BOM16_0); n_hdr++; commit_string();
    add(u16u8_pkg::BOM8_0); add(u16u8_pkg::BOM8_1); n_hdr++; commit_string();
    add(u16u8_pkg::BOM16_0); add(u16u8_pkg::BOM16_1); n_u16++; commit_string();
    add(u16u8_pkg::BOM16_0); add(8'h41); add(8'h42); n_hdr++; commit_string();
    add(u16u8_pkg::BOM8_0); add(u16u8_pkg::BOM8_1); add(u16u8_pkg::BOM8_2); n_u8++;
    commit_string();
    add(u16u8_pkg::BOM16_0); add(u16u8_pkg::BOM16_1); add16(16'hD800); n_u16++;
    commit_string();
    add(u16u8_pkg::BOM16_0); add(u16u8_pkg::BOM16_1); add16(16'h0041); add(8'h7F); n_u16++;
    commit_string();
    add(8'hFF); add(8'h00); n_raw++; commit_string();
    add(u16u8_pkg::BOM8_0); add(u16u8_pkg::BOM8_1); add(8'h00); n_hdr++; commit_string();
    pick = n_bytes;
    while (n_bytes - pick < RANDOM_BYTES) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7: gen_u16();
        8, 9, 10, 11:           gen_u8();
        12, 13, 14:             gen_raw();
        default:                gen_header_case();
      endcase
    end
  endtask

  // input driver
  int   in_gap = 0;
  logic in_burst = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap <= in_gap - 1;
      end else if (pending_bytes.size() > 0) begin
        in_data <= pending_bytes.pop_front();
        in_valid <= 1'b1;
        in_gap <= in_burst ? 0 : int'($urandom_range(0, MAX_IDLE));
        if ($urandom_range(0, 39) == 0) in_burst <= ~in_burst;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result-side ready
  int   out_stall = 0;
  int   stall_draw;
  logic out_burst = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_stall <= 0;
    end else if (out_valid && out_ready) begin
      stall_draw = out_burst ? 0 : int'($urandom_range(0, MAX_IDLE));
      if ($urandom_range(0, 39) == 0) out_burst <= ~out_burst;
      out_ready <= (stall_draw == 0);
      out_stall <= stall_draw;
    end else if (out_stall > 0) begin
      out_ready <= (out_stall == 1);
      out_stall <= out_stall - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // monitor: predict on input transaction, check on result transaction
  u16u8_pkg::out_item_t got, want;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) predict_utf8(in_data.in_byte, in_data.in_last);
      if (out_valid && out_ready) begin
        got = out_data;
        checked_cnt++;
        if (utf8_expected.size() == 0) begin
          $error("unexpected result transaction: out_byte %0h has_byte %0b raw %0b last %0b",
                 got.out_byte, got.has_byte, got.raw_doc_byte, got.out_last);
          err_cnt++;
        end else begin
          want = utf8_expected.pop_front();
          if (got.out_byte !== want.out_byte) begin
            $error("out_byte: expected %0h, got %0h", want.out_byte, got.out_byte);
            err_cnt++;
          end
          if (got.has_byte !== want.has_byte) begin
            $error("has_byte: expected %0b, got %0b", want.has_byte, got.has_byte);
            err_cnt++;
          end
          if (got.raw_doc_byte !== want.raw_doc_byte) begin
            $error("raw_doc_byte: expected %0b, got %0b", want.raw_doc_byte, got.raw_doc_byte);
            err_cnt++;
          end
          if (got.out_last !== want.out_last) begin
            $error("out_last: expected %0b, got %0b", want.out_last, got.out_last);
            err_cnt++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_cnt, utf8_expected.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    clear_state();
    build_stimulus();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (!(pending_bytes.size() == 0 && !in_valid && utf8_expected.size() == 0))
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (utf8_expected.size() != 0) begin
      $error("%0d expected results never arrived", utf8_expected.size());
      err_cnt++;
    end
    $display("%0d strings: %0d UTF-16BE, %0d UTF-8, %0d raw, %0d header cases; %0d bytes in",
             n_u16 + n_u8 + n_raw + n_hdr, n_u16, n_u8, n_raw, n_hdr, n_bytes);
    $display("%0d result transactions checked, %0d mismatches", checked_cnt, err_cnt);
    if (err_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
